// ===== design/sch_pkg.sv =====
// ----------------------------------------------------------------------------
// sch_pkg
// Shared types and constants for the substring compare-by-hash block.
// ----------------------------------------------------------------------------
package sch_pkg;

	localparam int HW = 30;

	typedef logic [HW-1:0] hash_t;
	typedef logic signed [1:0] order_t;

	localparam hash_t MOD_FIRST  = 30'd998244353;
	localparam hash_t MOD_SECOND = 30'd1000000007;
	localparam hash_t BASE_RESET = 30'd1337;

	localparam order_t ORDER_LESS    = -2'sd1;
	localparam order_t ORDER_EQUAL   = 2'sd0;
	localparam order_t ORDER_GREATER = 2'sd1;

	typedef enum logic {
		REG_BASE_FIRST  = 1'b0,
		REG_BASE_SECOND = 1'b1
	} reg_index_t;

	typedef enum logic {
		KIND_APPEND  = 1'b0,
		KIND_COMPARE = 1'b1
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_AMUL,
		S_AWR,
		S_LEN,
		S_MID,
		S_RD1,
		S_RD2,
		S_RD3,
		S_QMUL,
		S_CMP,
		S_BYTE,
		S_BYTEW,
		S_OUT
	} state_t;

	typedef struct packed {
		logic  start;
		hash_t a;
		hash_t b;
	} mul_req_t;

endpackage

// ===== design/sch_ram.sv =====
// ----------------------------------------------------------------------------
// sch_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module sch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== design/sch_modmul.sv =====
// ----------------------------------------------------------------------------
// sch_modmul
// Bit-serial modular multiplier: one bit of the first operand per cycle.
// ----------------------------------------------------------------------------
module sch_modmul #(
	parameter logic [29:0] MODULUS = 30'd998244353
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sch_pkg::mul_req_t req,
	output logic              done,
	output sch_pkg::hash_t    product
);
	import sch_pkg::*;

	localparam int CW = $clog2(HW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	hash_t         a_q;
	hash_t         b_q;
	hash_t         r_q;
	hash_t         b_red;
	hash_t         r_next;
	logic [HW+1:0] t;
	logic [HW+1:0] m1;
	logic [HW+1:0] m2;

	always_comb begin
		b_red = (req.b >= MODULUS) ? req.b - MODULUS : req.b;
		m1 = {2'b00, MODULUS};
		m2 = {1'b0, MODULUS, 1'b0};
		t = {1'b0, r_q, 1'b0} + (a_q[HW-1] ? {2'b00, b_q} : '0);
		priority if (t >= m2) begin
			r_next = hash_t'(t - m2);
		end else if (t >= m1) begin
			r_next = hash_t'(t - m1);
		end else begin
			r_next = hash_t'(t);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CW'(HW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= b_red;
			r_q <= '0;
		end else if (cnt_q != '0) begin
			a_q <= a_q << 1;
			r_q <= r_next;
		end
	end

	assign done    = done_q;
	assign product = r_q;

endmodule

// ===== design/substring_compare_by_hash.sv =====
// ----------------------------------------------------------------------------
// substring_compare_by_hash
// Polynomial-hash text store with longest-common-prefix substring compare.
// ----------------------------------------------------------------------------
// An append beat writes the byte and extends both prefix hashes and base
// powers with the bit-serial modular multipliers, four running side by side.
// A compare beat runs a binary search of at most S steps, where
// S = ceil(log2(shorter_length + 1)) (up to 17 at the default size); each
// step passes through the midpoint, memory-read, multiplier and hash
// compare states in that order.
// Appends give no result beat; each compare gives one on order. The next
// input beat is taken while a result still waits on the output.
// ----------------------------------------------------------------------------
module substring_compare_by_hash #(
	parameter int MAX_LEN = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                kind,
	input  logic [7:0]          char_value,
	input  logic [15:0]         first_lo,
	input  logic [15:0]         first_hi,
	input  logic [15:0]         second_lo,
	input  logic [15:0]         second_hi,
	output logic                out_valid,
	input  logic                out_ready,
	output sch_pkg::order_t     order,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [29:0]         cfg_data
);
	import sch_pkg::*;

	localparam int AW = $clog2(MAX_LEN + 1);
	localparam int TW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 2);

	state_t state_q, state_n;

	logic [AW-1:0] len_q;
	hash_t         base1_q, base2_q;
	hash_t         pow1_last_q, pow2_last_q, hsh1_last_q, hsh2_last_q;
	logic [7:0]    char_q;
	logic [15:0]   lo1_q, hi1_q, lo2_q, hi2_q;
	logic [AW-1:0] len1_q, len2_q, short_q;
	logic [CW-1:0] good_q, bad_q, mid_q;
	hash_t         hend_a1_q, hend_b1_q, hend_a2_q, hend_b2_q;
	hash_t         pw1_q, pw2_q;
	order_t        res_q;
	logic          out_valid_q;
	order_t        order_q;

	logic          accept;
	logic          app_go;
	logic          full;
	logic [31:0]   span1, span2, short_w;
	logic [CW:0]   sum_gb;
	logic          more;

	logic [AW-1:0] h_raddr_a, h_raddr_b, h_waddr, p_raddr;
	logic [TW-1:0] t_raddr_a, t_raddr_b;
	hash_t         h1_rd_a, h1_rd_b, h2_rd_a, h2_rd_b, p1_rd, p2_rd;
	hash_t         h1a, h1b, h2a, h2b;
	logic [7:0]    t_rd_a, t_rd_b;
	hash_t         pow1_new, pow2_new, hsh1_new, hsh2_new;
	logic [HW:0]   s1, s2;
	hash_t         sa1, sb1, sa2, sb2;
	logic          match;

	mul_req_t      rq_a1, rq_b1, rq_a2, rq_b2;
	logic          dn_a1, dn_b1, dn_a2, dn_b2, mul_done;
	hash_t         pr_a1, pr_b1, pr_a2, pr_b2;

	function automatic logic [31:0] span_len(input logic [15:0] lo, input logic [15:0] hi,
			input logic [31:0] tl);
		logic [31:0] h;
		if (tl == 32'd0) begin
			return 32'd0;
		end
		h = (32'(hi) >= tl) ? tl - 32'd1 : 32'(hi);
		return (32'(lo) <= h) ? h - 32'(lo) + 32'd1 : 32'd0;
	endfunction

	function automatic hash_t sub_mod(input hash_t x, input hash_t y, input hash_t m);
		return (x >= y) ? x - y : x + (m - y);
	endfunction

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign full     = (len_q == AW'(MAX_LEN));
	assign app_go   = accept && (kind == KIND_APPEND) && !full;

	always_comb begin
		span1   = span_len(lo1_q, hi1_q, 32'(len_q));
		span2   = span_len(lo2_q, hi2_q, 32'(len_q));
		short_w = (span1 < span2) ? span1 : span2;
		sum_gb  = {1'b0, good_q} + {1'b0, bad_q};
		more    = ({1'b0, good_q} + 1'b1) < {1'b0, bad_q};
	end

	// memory addressing
	always_comb begin
		h_raddr_a = AW'(lo1_q) + ((state_q == S_RD1) ? AW'(mid_q) : '0);
		h_raddr_b = AW'(lo2_q) + ((state_q == S_RD1) ? AW'(mid_q) : '0);
		p_raddr   = AW'(mid_q);
		h_waddr   = len_q + 1'b1;
		t_raddr_a = TW'(AW'(lo1_q) + AW'(good_q));
		t_raddr_b = TW'(AW'(lo2_q) + AW'(good_q));
	end

	sch_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text (
		.clk(clk), .we(app_go), .waddr(TW'(len_q)), .wdata(char_value),
		.raddr_a(t_raddr_a), .rdata_a(t_rd_a), .raddr_b(t_raddr_b), .rdata_b(t_rd_b)
	);

	sch_ram #(.WIDTH(HW), .DEPTH(MAX_LEN + 1)) u_hash1 (
		.clk(clk), .we(state_q == S_AWR), .waddr(h_waddr), .wdata(hsh1_new),
		.raddr_a(h_raddr_a), .rdata_a(h1_rd_a), .raddr_b(h_raddr_b), .rdata_b(h1_rd_b)
	);

	sch_ram #(.WIDTH(HW), .DEPTH(MAX_LEN + 1)) u_hash2 (
		.clk(clk), .we(state_q == S_AWR), .waddr(h_waddr), .wdata(hsh2_new),
		.raddr_a(h_raddr_a), .rdata_a(h2_rd_a), .raddr_b(h_raddr_b), .rdata_b(h2_rd_b)
	);

	sch_ram #(.WIDTH(HW), .DEPTH(MAX_LEN + 1)) u_pow1 (
		.clk(clk), .we(state_q == S_AWR), .waddr(h_waddr), .wdata(pow1_new),
		.raddr_a(p_raddr), .rdata_a(p1_rd), .raddr_b(p_raddr), .rdata_b()
	);

	sch_ram #(.WIDTH(HW), .DEPTH(MAX_LEN + 1)) u_pow2 (
		.clk(clk), .we(state_q == S_AWR), .waddr(h_waddr), .wdata(pow2_new),
		.raddr_a(p_raddr), .rdata_a(p2_rd), .raddr_b(p_raddr), .rdata_b()
	);

	// entry zero of the prefix hashes is never written: read it as zero
	always_comb begin
		h1a = (lo1_q == '0) ? '0 : h1_rd_a;
		h2a = (lo1_q == '0) ? '0 : h2_rd_a;
		h1b = (lo2_q == '0) ? '0 : h1_rd_b;
		h2b = (lo2_q == '0) ? '0 : h2_rd_b;
	end

	// multiplier requests
	always_comb begin
		rq_a1.start = app_go || (state_q == S_RD3);
		rq_b1.start = rq_a1.start;
		rq_a2.start = rq_a1.start;
		rq_b2.start = rq_a1.start;
		if (state_q == S_RD3) begin
			rq_a1.a = h1a; rq_a1.b = pw1_q;
			rq_b1.a = h1b; rq_b1.b = pw1_q;
			rq_a2.a = h2a; rq_a2.b = pw2_q;
			rq_b2.a = h2b; rq_b2.b = pw2_q;
		end else begin
			rq_a1.a = pow1_last_q; rq_a1.b = base1_q;
			rq_b1.a = hsh1_last_q; rq_b1.b = base1_q;
			rq_a2.a = pow2_last_q; rq_a2.b = base2_q;
			rq_b2.a = hsh2_last_q; rq_b2.b = base2_q;
		end
	end

	sch_modmul #(.MODULUS(MOD_FIRST)) u_mul_a1 (
		.clk(clk), .arst_n(arst_n), .req(rq_a1), .done(dn_a1), .product(pr_a1)
	);
	sch_modmul #(.MODULUS(MOD_FIRST)) u_mul_b1 (
		.clk(clk), .arst_n(arst_n), .req(rq_b1), .done(dn_b1), .product(pr_b1)
	);
	sch_modmul #(.MODULUS(MOD_SECOND)) u_mul_a2 (
		.clk(clk), .arst_n(arst_n), .req(rq_a2), .done(dn_a2), .product(pr_a2)
	);
	sch_modmul #(.MODULUS(MOD_SECOND)) u_mul_b2 (
		.clk(clk), .arst_n(arst_n), .req(rq_b2), .done(dn_b2), .product(pr_b2)
	);

	assign mul_done = dn_a1 && dn_b1 && dn_a2 && dn_b2;

	always_comb begin
		pow1_new = pr_a1;
		pow2_new = pr_a2;
		s1 = {1'b0, pr_b1} + (HW + 1)'(char_q);
		s2 = {1'b0, pr_b2} + (HW + 1)'(char_q);
		hsh1_new = (s1 >= {1'b0, MOD_FIRST}) ? hash_t'(s1 - {1'b0, MOD_FIRST}) : hash_t'(s1);
		hsh2_new = (s2 >= {1'b0, MOD_SECOND}) ? hash_t'(s2 - {1'b0, MOD_SECOND})
			: hash_t'(s2);
		sa1 = sub_mod(hend_a1_q, pr_a1, MOD_FIRST);
		sb1 = sub_mod(hend_b1_q, pr_b1, MOD_FIRST);
		sa2 = sub_mod(hend_a2_q, pr_a2, MOD_SECOND);
		sb2 = sub_mod(hend_b2_q, pr_b2, MOD_SECOND);
		match = (sa1 == sb1) && (sa2 == sb2);
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (kind == KIND_COMPARE) begin
						state_n = S_LEN;
					end else if (!full) begin
						state_n = S_AMUL;
					end
				end
			end
			S_AMUL:  if (mul_done) state_n = S_AWR;
			S_AWR:   state_n = S_IDLE;
			S_LEN:   state_n = S_MID;
			S_MID:   state_n = more ? S_RD1 : S_BYTE;
			S_RD1:   state_n = S_RD2;
			S_RD2:   state_n = S_RD3;
			S_RD3:   state_n = S_QMUL;
			S_QMUL:  if (mul_done) state_n = S_CMP;
			S_CMP:   state_n = S_MID;
			S_BYTE: begin
				if ((good_q < CW'(short_q)) &&
						!((good_q == CW'(len1_q)) && (len1_q < len2_q)) &&
						!((good_q == CW'(len2_q)) && (len2_q < len1_q))) begin
					state_n = S_BYTEW;
				end else begin
					state_n = S_OUT;
				end
			end
			S_BYTEW: state_n = S_OUT;
			S_OUT:   if (!out_valid_q || out_ready) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			base1_q     <= BASE_RESET;
			base2_q     <= BASE_RESET;
			pow1_last_q <= hash_t'(1);
			pow2_last_q <= hash_t'(1);
			hsh1_last_q <= '0;
			hsh2_last_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				unique case (reg_index_t'(cfg_index))
					REG_BASE_FIRST:  base1_q <= cfg_data;
					REG_BASE_SECOND: base2_q <= cfg_data;
				endcase
			end
			if (state_q == S_AWR) begin
				len_q       <= len_q + 1'b1;
				pow1_last_q <= pow1_new;
				pow2_last_q <= pow2_new;
				hsh1_last_q <= hsh1_new;
				hsh2_last_q <= hsh2_new;
			end
			if ((state_q == S_OUT) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_q <= char_value;
			lo1_q  <= first_lo;
			hi1_q  <= first_hi;
			lo2_q  <= second_lo;
			hi2_q  <= second_hi;
		end
		unique case (state_q)
			S_LEN: begin
				len1_q  <= AW'(span1);
				len2_q  <= AW'(span2);
				short_q <= AW'(short_w);
				good_q  <= '0;
				bad_q   <= CW'(short_w) + 1'b1;
			end
			S_MID: mid_q <= CW'(sum_gb >> 1);
			S_RD2: begin
				hend_a1_q <= h1_rd_a;
				hend_b1_q <= h1_rd_b;
				hend_a2_q <= h2_rd_a;
				hend_b2_q <= h2_rd_b;
				pw1_q     <= p1_rd;
				pw2_q     <= p2_rd;
			end
			S_CMP: begin
				if (match) begin
					good_q <= mid_q;
				end else begin
					bad_q <= mid_q;
				end
			end
			S_BYTE: begin
				priority if ((good_q == CW'(len1_q)) && (len1_q < len2_q)) begin
					res_q <= ORDER_LESS;
				end else if ((good_q == CW'(len2_q)) && (len2_q < len1_q)) begin
					res_q <= ORDER_GREATER;
				end else begin
					res_q <= ORDER_EQUAL;
				end
			end
			S_BYTEW: res_q <= (t_rd_a > t_rd_b) ? ORDER_GREATER : ORDER_LESS;
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					order_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign order     = order_q;

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for substring_compare_by_hash. A short directed table
// (empty text, byte extremes, empty and clamped substrings, prefixes) is
// followed by random appends and compares, mostly in range over a
// two-letter text so that long common prefixes occur. Every compare result
// is checked against the table or an in-bench hash model. The hash bases
// are rewritten between phases; the text capacity is kept small so it fills.
// ----------------------------------------------------------------------------
module testbench;
	import sch_pkg::*;

	localparam int TEXT_CAP = 128;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		kind_t       op;
		logic [7:0]  ch;
		logic [15:0] lo1, hi1, lo2, hi2;
		bit          typed;
		order_t      want;
	} stim_t;

	logic        clk, arst_n;
	logic        in_valid, in_ready, out_valid, out_ready;
	logic        kind;
	logic [7:0]  char_value;
	logic [15:0] first_lo, first_hi, second_lo, second_hi;
	order_t      order;
	logic        cfg_we;
	logic        cfg_index;
	logic [29:0] cfg_data;

	hash_t       mdl_base1, mdl_base2;
	int unsigned text_len;
	logic [7:0]  text_bytes[TEXT_CAP];
	hash_t       pre1[TEXT_CAP+1], pre2[TEXT_CAP+1], pow1[TEXT_CAP+1], pow2[TEXT_CAP+1];
	order_t      pending_orders[$];
	int          fail_count = 0;
	bit          idle_on = 1;

	substring_compare_by_hash #(.MAX_LEN(TEXT_CAP)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .char_value(char_value),
		.first_lo(first_lo), .first_hi(first_hi),
		.second_lo(second_lo), .second_hi(second_hi),
		.out_valid(out_valid), .out_ready(out_ready), .order(order),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic hash_t mulmod(hash_t a, hash_t b, hash_t m);
		logic [63:0] p;
		p = 64'(a) * 64'(b);
		return hash_t'(p % 64'(m));
	endfunction

	function automatic hash_t span_hash(bit second, int unsigned a, int unsigned m);
		hash_t md, hi, lo;
		md = second ? MOD_SECOND : MOD_FIRST;
		hi = second ? pre2[a+m] : pre1[a+m];
		lo = mulmod(second ? pre2[a] : pre1[a], second ? pow2[m] : pow1[m], md);
		return hi >= lo ? hi - lo : hi + (md - lo);
	endfunction

	function automatic int unsigned span_len(int unsigned lo, int unsigned hi);
		if (text_len == 0) return 0;
		if (hi >= text_len) hi = text_len - 1;
		return lo <= hi ? hi - lo + 1 : 0;
	endfunction

	function automatic order_t compare_spans(int unsigned lo1, hi1, lo2, hi2);
		int unsigned l1, l2, shorter, good, bad, mid;
		l1 = span_len(lo1, hi1);
		l2 = span_len(lo2, hi2);
		shorter = l1 < l2 ? l1 : l2;
		good = 0;
		bad = shorter + 1;
		while (good + 1 < bad) begin
			mid = (good + bad) / 2;
			if (span_hash(0, lo1, mid) == span_hash(0, lo2, mid) &&
					span_hash(1, lo1, mid) == span_hash(1, lo2, mid))
				good = mid;
			else
				bad = mid;
		end
		if (good == l1 && l1 < l2) return ORDER_LESS;
		if (good == l2 && l2 < l1) return ORDER_GREATER;
		if (good < shorter)
			return text_bytes[lo1+good] > text_bytes[lo2+good] ? ORDER_GREATER : ORDER_LESS;
		return ORDER_EQUAL;
	endfunction

	function automatic void append_byte(logic [7:0] c);
		hash_t s1, s2;
		if (text_len >= TEXT_CAP) return;
		text_bytes[text_len] = c;
		pow1[text_len+1] = mulmod(pow1[text_len], mdl_base1, MOD_FIRST);
		pow2[text_len+1] = mulmod(pow2[text_len], mdl_base2, MOD_SECOND);
		s1 = mulmod(pre1[text_len], mdl_base1, MOD_FIRST) + c;
		s2 = mulmod(pre2[text_len], mdl_base2, MOD_SECOND) + c;
		pre1[text_len+1] = s1 >= MOD_FIRST ? s1 - MOD_FIRST : s1;
		pre2[text_len+1] = s2 >= MOD_SECOND ? s2 - MOD_SECOND : s2;
		text_len++;
	endfunction

	task automatic send(stim_t s);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= s.op;
		char_value <= s.ch;
		first_lo   <= s.lo1;
		first_hi   <= s.hi1;
		second_lo  <= s.lo2;
		second_hi  <= s.hi2;
		do @(posedge clk); while (!in_ready);
		if (s.op == KIND_APPEND)
			append_byte(s.ch);
		else if (s.typed)
			pending_orders.push_back(s.want);
		else
			pending_orders.push_back(compare_spans(s.lo1, s.hi1, s.lo2, s.hi2));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_orders.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_base(reg_index_t idx, hash_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BASE_FIRST) mdl_base1 = val;
		else mdl_base2 = val;
		@(posedge clk);
	endtask

	function automatic stim_t random_item();
		stim_t s;
		int unsigned a, b;
		s.typed = 0;
		s.want = ORDER_EQUAL;
		s.ch = $urandom_range(0, 3) == 0 ? 8'($urandom) : ($urandom_range(0, 1) ? 8'h61 : 8'h62);
		s.lo1 = 16'($urandom);
		s.hi1 = 16'($urandom);
		s.lo2 = 16'($urandom);
		s.hi2 = 16'($urandom);
		s.op = $urandom_range(0, 99) < 35 ? KIND_APPEND : KIND_COMPARE;
		if (s.op == KIND_COMPARE && text_len > 0 && $urandom_range(0, 7) != 0) begin
			a = $urandom_range(0, text_len - 1);
			b = $urandom_range(0, text_len - 1);
			s.lo1 = 16'(a);
			s.lo2 = 16'($urandom_range(0, 3) == 0 ? a : b);
			s.hi1 = $urandom_range(0, 5) == 0 ? 16'hFFFF : 16'($urandom_range(a, text_len - 1));
			s.hi2 = 16'(32'(s.lo2) + $urandom_range(0, text_len - s.lo2) - 1);
		end
		return s;
	endfunction

	stim_t directed[$] = '{
		'{KIND_COMPARE, 8'h00, 16'd0, 16'd0, 16'd0, 16'd0, 1, ORDER_EQUAL},
		'{KIND_APPEND, 8'h00, 16'd0, 16'd0, 16'd0, 16'd0, 0, ORDER_EQUAL},
		'{KIND_APPEND, 8'hFF, 16'd0, 16'd0, 16'd0, 16'd0, 0, ORDER_EQUAL},
		'{KIND_APPEND, 8'hFF, 16'd0, 16'd0, 16'd0, 16'd0, 0, ORDER_EQUAL},
		'{KIND_APPEND, 8'h00, 16'd0, 16'd0, 16'd0, 16'd0, 0, ORDER_EQUAL},
		'{KIND_APPEND, 8'h80, 16'd0, 16'd0, 16'd0, 16'd0, 0, ORDER_EQUAL},
		'{KIND_APPEND, 8'h7F, 16'd0, 16'd0, 16'd0, 16'd0, 0, ORDER_EQUAL},
		'{KIND_COMPARE, 8'h00, 16'd0, 16'd0, 16'd3, 16'd3, 1, ORDER_EQUAL},
		'{KIND_COMPARE, 8'h00, 16'd0, 16'd0, 16'd1, 16'd1, 1, ORDER_LESS},
		'{KIND_COMPARE, 8'h00, 16'd1, 16'd2, 16'd1, 16'd1, 1, ORDER_GREATER},
		'{KIND_COMPARE, 8'h00, 16'd2, 16'd1, 16'd5, 16'd4, 1, ORDER_EQUAL},
		'{KIND_COMPARE, 8'h00, 16'd3, 16'd2, 16'd0, 16'd0, 1, ORDER_LESS},
		'{KIND_COMPARE, 8'h00, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 1, ORDER_EQUAL},
		'{KIND_COMPARE, 8'h00, 16'hFFFF, 16'hFFFF, 16'd0, 16'd5, 1, ORDER_LESS},
		'{KIND_COMPARE, 8'h00, 16'd1, 16'd5, 16'd2, 16'd5, 0, ORDER_EQUAL},
		'{KIND_COMPARE, 8'h00, 16'd4, 16'd5, 16'd5, 16'hFFFF, 0, ORDER_EQUAL},
		'{KIND_COMPARE, 8'h00, 16'd0, 16'd3, 16'd3, 16'd5, 0, ORDER_EQUAL}
	};

	hash_t first_bases[5]  = '{30'd1, 30'd998244352, 30'h3FFFFFFF, 30'd998244353, 30'd0};
	hash_t second_bases[5] = '{30'd1000000006, 30'd1, 30'd1000000007, 30'h3FFFFFFF, 30'd0};

	initial begin
		in_valid = 0; kind = 0; char_value = 0;
		first_lo = 0; first_hi = 0; second_lo = 0; second_hi = 0;
		cfg_we = 0; cfg_index = 0; cfg_data = 0;
		mdl_base1 = BASE_RESET;
		mdl_base2 = BASE_RESET;
		text_len = 0;
		pre1[0] = 0; pre2[0] = 0; pow1[0] = 1; pow2[0] = 1;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) send(directed[i]);
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			write_base(REG_BASE_FIRST, ph == 4 ? hash_t'($urandom_range(1, 998244352)) : first_bases[ph]);
			write_base(REG_BASE_SECOND, ph == 4 ? hash_t'($urandom_range(1, 1000000006)) : second_bases[ph]);
			if (ph == 4) idle_on = 0;
			repeat (140) send(random_item());
		end
		drain();
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (idle_on && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_orders.size() == 0) begin
				$error("order: unexpected beat, actual %0d", order);
				fail_count++;
			end else begin
				if (order !== pending_orders[0]) begin
					$error("order: expected %0d actual %0d", pending_orders[0], order);
					fail_count++;
				end
				void'(pending_orders.pop_front());
			end
		end
	end

	initial begin
		#40_000_000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
